FILE: rtl/swa_pkg.sv
// package for the signal window aggregator: field widths, command codes,
// table entry layout and sequencer states. no dependencies
`default_nettype none
package swa_pkg;

   localparam int ID_W        = 31;
   localparam int STR_W       = 8;
   localparam int MAG_W       = 7;
   localparam int SUM_W       = 24;
   localparam int CNT_W       = 16;
   localparam int AVG_W       = 11;
   localparam int FRAC_W      = 4;
   localparam int DIVIDEND_W  = SUM_W + FRAC_W;
   localparam int STEP_W      = $clog2(AVG_W);
   localparam int RES_LIMIT   = 32;
   localparam int RES_CNT_W   = $clog2(RES_LIMIT + 1);

   localparam logic [STR_W-1:0] INVALID_STRENGTH = 8'd99;
   localparam logic [CNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_REPORT   = 2'd0,
      CMD_LINE_END = 2'd1,
      CMD_CLOSE    = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] seen;
      logic             serving;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             done;
      logic [AVG_W-1:0] quotient;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_CLOSE_READ,
      ST_CLOSE_EVAL,
      ST_CLOSE_PUSH,
      ST_CLOSE_DIV,
      ST_CLOSE_END
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/swa_if.sv
// channel interfaces for the report input and the result output
// depends on swa_pkg
`default_nettype none
interface swa_req_if;
   import swa_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic [ID_W-1:0]         transmitter_id;
   logic signed [STR_W-1:0] strength;
   logic                    serving;

   modport source (output valid, command, transmitter_id, strength, serving, input ready);
   modport sink   (input valid, command, transmitter_id, strength, serving, output ready);
endinterface

interface swa_rsp_if;
   import swa_pkg::*;
   logic             valid;
   logic             ready;
   logic             entry_valid;
   logic [ID_W-1:0]  entry_id;
   logic [AVG_W-1:0] average_strength;
   logic             was_serving;
   logic [CNT_W-1:0] dropped_reports;
   logic             last;

   modport source (output valid, entry_valid, entry_id, average_strength, was_serving,
                   dropped_reports, last, input ready);
   modport sink   (input valid, entry_valid, entry_id, average_strength, was_serving,
                   dropped_reports, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/swa_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module swa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/swa_div.sv
// restoring divider for the average: (sum * 16) / seen, one quotient bit a cycle
// depends on swa_pkg
`default_nettype none
module swa_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [swa_pkg::SUM_W-1:0]    dividend,
   input  wire logic [swa_pkg::CNT_W-1:0]    divisor,
   output swa_pkg::div_status_type           status
);
   import swa_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [AVG_W-1:0]        low_ff, low_in;
   logic [AVG_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        div_ff, div_in;
   logic [DIVIDEND_W-1:0]   numer;
   logic [CNT_W:0]          trial;
   logic                    fits;

   // quotient is below 2^11 since sum <= 127 * seen, so the top part starts below seen
   assign numer = {dividend, {FRAC_W{1'b0}}};
   assign trial = {rem_ff, low_ff[AVG_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = numer[AVG_W+CNT_W-1:AVG_W];
         low_in  = numer[AVG_W-1:0];
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         low_in  = {low_ff[AVG_W-2:0], 1'b0};
         quo_in  = {quo_ff[AVG_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(AVG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/signal_window_aggregator_top.sv
// top level of the signal window aggregator: sequencer around the entry table
// depends on swa_pkg, swa_if, swa_ram, swa_div
//
//   channel  dir  contents
//   req      in   command, transmitter_id, strength, serving
//   rsp      out  entry_valid, entry_id, average_strength, was_serving,
//                 dropped_reports, last
//
// a report is handled after acceptance by the read latency of the table, one compare per
// stored entry through the single read port, an insert or drop state and the return to
// idle; a hit returns early, an empty table goes straight to insert. line end, unknown
// commands and ignored reports are handled in the idle state. close reads and evaluates
// each stored entry, pushes and runs the 11-step divide for each kept entry, then closes,
// and output stalls add to that. reset is synchronous; the table needs no
// clearing. a new transaction is taken as soon as the sequencer is idle, even while the
// last result still waits in the output register.
`default_nettype none
module signal_window_aggregator_top #(
   parameter int TABLE_DEPTH = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   swa_req_if.sink    req_chan,
   swa_rsp_if.source  rsp_chan
);
   import swa_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int USED_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [USED_W-1:0] USED_FULL = USED_W'(TABLE_DEPTH);

   state_type              state_ff, state_in;
   logic [USED_W-1:0]      used_ff, used_in;
   logic [CNT_W-1:0]       line_ff, line_in;
   logic [CNT_W-1:0]       drop_ff, drop_in;
   logic [USED_W-1:0]      ptr_ff, ptr_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [USED_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                   pend_ff, pend_in;
   logic [RES_CNT_W-1:0]   kept_ff, kept_in;
   logic                   out_vld_ff, out_vld_in;

   logic [ID_W-1:0]        item_id_ff, item_id_in;
   logic [MAG_W-1:0]       item_str_ff, item_str_in;
   logic                   item_srv_ff, item_srv_in;
   entry_type              cur_ff, cur_in;
   logic [ID_W-1:0]        pend_id_ff, pend_id_in;
   logic [AVG_W-1:0]       pend_avg_ff, pend_avg_in;
   logic                   pend_srv_ff, pend_srv_in;
   logic                   out_ent_ff, out_ent_in;
   logic [ID_W-1:0]        out_id_ff, out_id_in;
   logic [AVG_W-1:0]       out_avg_ff, out_avg_in;
   logic                   out_srv_ff, out_srv_in;
   logic [CNT_W-1:0]       out_drop_ff, out_drop_in;
   logic                   out_last_ff, out_last_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   entry_type              ram_wdata;
   entry_type              ram_rdata;
   logic                   div_start;
   div_status_type         div_stat;

   logic                   accept;
   logic                   str_ok;
   logic                   hit;
   logic                   last_chk;
   logic                   keep;
   logic                   slot_free;
   entry_type              upd;

   swa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   swa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur_ff.sum),
      .divisor  (cur_ff.seen),
      .status   (div_stat)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign str_ok         = !req_chan.strength[STR_W-1] &&
                           (req_chan.strength != INVALID_STRENGTH);
   assign hit            = chk_vld_ff && (ram_rdata.id == item_id_ff);
   assign last_chk       = (chk_idx_ff + USED_W'(1)) == used_ff;
   assign keep           = {ram_rdata.seen, 1'b0} > {1'b0, line_ff};
   assign slot_free      = !out_vld_ff || rsp_chan.ready;

   always_comb begin
      upd = ram_rdata;
      if (ram_rdata.seen != COUNT_MAX) begin
         upd.sum  = ram_rdata.sum + SUM_W'(item_str_ff);
         upd.seen = ram_rdata.seen + CNT_W'(1);
      end
      upd.serving = ram_rdata.serving | item_srv_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_chan.command))
                  CMD_REPORT: begin
                     if (str_ok) begin
                        state_in = (used_ff == '0) ? ST_INSERT : ST_SCAN;
                     end
                  end
                  CMD_CLOSE: state_in = ST_CLOSE_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_IDLE;
            end else if (chk_vld_ff && last_chk) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT:     state_in = ST_IDLE;
         ST_CLOSE_READ: state_in = (ptr_ff == used_ff) ? ST_CLOSE_END : ST_CLOSE_EVAL;
         ST_CLOSE_EVAL: begin
            if (!keep) begin
               state_in = ST_CLOSE_READ;
            end else if (kept_ff == RES_CNT_W'(RES_LIMIT)) begin
               state_in = ST_CLOSE_END;
            end else begin
               state_in = ST_CLOSE_PUSH;
            end
         end
         ST_CLOSE_PUSH: begin
            if (!pend_ff || slot_free) begin
               state_in = ST_CLOSE_DIV;
            end
         end
         ST_CLOSE_DIV: begin
            if (div_stat.done) begin
               state_in = ST_CLOSE_READ;
            end
         end
         ST_CLOSE_END: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      used_in     = used_ff;
      line_in     = line_ff;
      drop_in     = drop_ff;
      ptr_in      = ptr_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      pend_in     = pend_ff;
      kept_in     = kept_ff;
      item_id_in  = item_id_ff;
      item_str_in = item_str_ff;
      item_srv_in = item_srv_ff;
      cur_in      = cur_ff;
      pend_id_in  = pend_id_ff;
      pend_avg_in = pend_avg_ff;
      pend_srv_in = pend_srv_ff;
      out_vld_in  = out_vld_ff && !rsp_chan.ready;
      out_ent_in  = out_ent_ff;
      out_id_in   = out_id_ff;
      out_avg_in  = out_avg_ff;
      out_srv_in  = out_srv_ff;
      out_drop_in = out_drop_ff;
      out_last_in = out_last_ff;
      ram_we      = 1'b0;
      ram_waddr   = chk_idx_ff[IDX_W-1:0];
      ram_wdata   = upd;
      div_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_id_in  = req_chan.transmitter_id;
               item_str_in = req_chan.strength[MAG_W-1:0];
               item_srv_in = req_chan.serving;
               ptr_in      = '0;
               kept_in     = '0;
               pend_in     = 1'b0;
               case (cmd_type'(req_chan.command))
                  CMD_LINE_END: begin
                     if (line_ff != COUNT_MAX) begin
                        line_in = line_ff + CNT_W'(1);
                     end
                  end
                  default: line_in = line_ff;
               endcase
            end
         end
         ST_SCAN: begin
            chk_vld_in = ptr_ff < used_ff;
            chk_idx_in = ptr_ff;
            ptr_in     = ptr_ff + USED_W'(1);
            if (hit) begin
               ram_we = 1'b1;
            end
         end
         ST_INSERT: begin
            if (used_ff != USED_FULL) begin
               ram_we            = 1'b1;
               ram_waddr         = used_ff[IDX_W-1:0];
               ram_wdata.id      = item_id_ff;
               ram_wdata.sum     = SUM_W'(item_str_ff);
               ram_wdata.seen    = CNT_W'(1);
               ram_wdata.serving = item_srv_ff;
               used_in           = used_ff + USED_W'(1);
            end else if (drop_ff != COUNT_MAX) begin
               drop_in = drop_ff + CNT_W'(1);
            end
         end
         ST_CLOSE_READ: begin
            ptr_in = ptr_ff;
         end
         ST_CLOSE_EVAL: begin
            cur_in = ram_rdata;
            if (!keep) begin
               ptr_in = ptr_ff + USED_W'(1);
            end
         end
         ST_CLOSE_PUSH: begin
            if (!pend_ff || slot_free) begin
               div_start = 1'b1;
               if (pend_ff) begin
                  out_vld_in  = 1'b1;
                  out_ent_in  = 1'b1;
                  out_id_in   = pend_id_ff;
                  out_avg_in  = pend_avg_ff;
                  out_srv_in  = pend_srv_ff;
                  out_drop_in = drop_ff;
                  out_last_in = 1'b0;
                  pend_in     = 1'b0;
               end
            end
         end
         ST_CLOSE_DIV: begin
            if (div_stat.done) begin
               pend_in     = 1'b1;
               pend_id_in  = cur_ff.id;
               pend_avg_in = div_stat.quotient;
               pend_srv_in = cur_ff.serving;
               kept_in     = kept_ff + RES_CNT_W'(1);
               ptr_in      = ptr_ff + USED_W'(1);
            end
         end
         ST_CLOSE_END: begin
            if (slot_free) begin
               out_vld_in  = 1'b1;
               out_ent_in  = pend_ff;
               out_id_in   = pend_ff ? pend_id_ff : '0;
               out_avg_in  = pend_ff ? pend_avg_ff : '0;
               out_srv_in  = pend_ff && pend_srv_ff;
               out_drop_in = drop_ff;
               out_last_in = 1'b1;
               pend_in     = 1'b0;
               used_in     = '0;
               line_in     = '0;
               drop_in     = '0;
            end
         end
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         line_ff    <= '0;
         drop_ff    <= '0;
         ptr_ff     <= '0;
         chk_vld_ff <= 1'b0;
         chk_idx_ff <= '0;
         pend_ff    <= 1'b0;
         kept_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         line_ff    <= line_in;
         drop_ff    <= drop_in;
         ptr_ff     <= ptr_in;
         chk_vld_ff <= chk_vld_in;
         chk_idx_ff <= chk_idx_in;
         pend_ff    <= pend_in;
         kept_ff    <= kept_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_id_ff  <= item_id_in;
      item_str_ff <= item_str_in;
      item_srv_ff <= item_srv_in;
      cur_ff      <= cur_in;
      pend_id_ff  <= pend_id_in;
      pend_avg_ff <= pend_avg_in;
      pend_srv_ff <= pend_srv_in;
      out_ent_ff  <= out_ent_in;
      out_id_ff   <= out_id_in;
      out_avg_ff  <= out_avg_in;
      out_srv_ff  <= out_srv_in;
      out_drop_ff <= out_drop_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid            = out_vld_ff;
   assign rsp_chan.entry_valid      = out_ent_ff;
   assign rsp_chan.entry_id         = out_id_ff;
   assign rsp_chan.average_strength = out_avg_ff;
   assign rsp_chan.was_serving      = out_srv_ff;
   assign rsp_chan.dropped_reports  = out_drop_ff;
   assign rsp_chan.last             = out_last_ff;
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for signal_window_aggregator_top: directed windows, full table,
// output backpressure and random windows, all checked against a window predictor
// depends on swa_pkg, swa_if and the rtl of the block
module testbench;
   import swa_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_PAD = TABLE_DEPTH + 8;
   localparam int HOLD_OFF = 400;
   localparam int RANDOM_ITEMS = 330;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   typedef struct packed {
      logic             entry_valid;
      logic [ID_W-1:0]  entry_id;
      logic [AVG_W-1:0] average_strength;
      logic             was_serving;
      logic [CNT_W-1:0] dropped_reports;
      logic             last;
   } window_result_type;

   logic clock;
   logic reset;

   swa_req_if req_if ();
   swa_rsp_if rsp_if ();

   signal_window_aggregator_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // window predictor state
   logic [ID_W-1:0]  win_id   [TABLE_DEPTH];
   logic [SUM_W-1:0] win_sum  [TABLE_DEPTH];
   logic [CNT_W-1:0] win_seen [TABLE_DEPTH];
   logic             win_srv  [TABLE_DEPTH];
   int               win_used;
   logic [CNT_W-1:0] win_lines;
   logic [CNT_W-1:0] win_drops;

   window_result_type expected_window_results[$];

   int  mismatches;
   int  items_sent;
   int  results_checked;
   int  windows_closed;
   int  rsp_hold;
   bit  sender_quiet;
   bit  receiver_quiet;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit entry_kept(input int k);
      return 2 * 32'(win_seen[k]) > 32'(win_lines);
   endfunction

   task automatic predict_window_step(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                                      input logic signed [STR_W-1:0] str, input logic srv);
      window_result_type r;
      logic [DIVIDEND_W-1:0] dividend;
      int hit;
      int n_keep;
      int kept;
      case (cmd)
         CMD_REPORT: begin
            if (!str[STR_W-1] && str != INVALID_STRENGTH) begin
               hit = -1;
               for (int k = 0; k < win_used; k++)
                  if (hit < 0 && win_id[k] == id) hit = k;
               if (hit >= 0) begin
                  if (win_seen[hit] != COUNT_MAX) begin
                     win_sum[hit] = win_sum[hit] + SUM_W'(str[MAG_W-1:0]);
                     win_seen[hit] = win_seen[hit] + 1'b1;
                  end
                  win_srv[hit] = win_srv[hit] | srv;
               end else if (win_used < TABLE_DEPTH) begin
                  win_id[win_used] = id;
                  win_sum[win_used] = SUM_W'(str[MAG_W-1:0]);
                  win_seen[win_used] = CNT_W'(1);
                  win_srv[win_used] = srv;
                  win_used++;
               end else if (win_drops != COUNT_MAX) begin
                  win_drops = win_drops + 1'b1;
               end
            end
         end
         CMD_LINE_END: begin
            if (win_lines != COUNT_MAX) win_lines = win_lines + 1'b1;
         end
         CMD_CLOSE: begin
            n_keep = 0;
            for (int k = 0; k < win_used; k++)
               if (entry_kept(k)) n_keep++;
            if (n_keep > RES_LIMIT) n_keep = RES_LIMIT;
            kept = 0;
            for (int k = 0; k < win_used; k++) begin
               if (kept < n_keep && entry_kept(k)) begin
                  dividend = {win_sum[k], FRAC_W'(0)};
                  r.entry_valid = 1'b1;
                  r.entry_id = win_id[k];
                  r.average_strength = AVG_W'(dividend / win_seen[k]);
                  r.was_serving = win_srv[k];
                  r.dropped_reports = win_drops;
                  r.last = (kept == n_keep - 1);
                  expected_window_results.push_back(r);
                  kept++;
               end
            end
            if (n_keep == 0) begin
               r = '0;
               r.dropped_reports = win_drops;
               r.last = 1'b1;
               expected_window_results.push_back(r);
            end
            win_used = 0;
            win_lines = '0;
            win_drops = '0;
            windows_closed++;
         end
         default: ;
      endcase
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_item(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                             input logic signed [STR_W-1:0] str, input logic srv);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.transmitter_id <= id;
      req_if.strength <= str;
      req_if.serving <= srv;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      predict_window_step(cmd, id, str, srv);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_window();
      req_if.valid <= 1'b0;
      while (expected_window_results.size() != 0) @(negedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   function automatic logic signed [STR_W-1:0] pick_strength();
      case ($urandom_range(0, 15))
         0, 1:    return STR_W'($urandom);
         2:       return INVALID_STRENGTH;
         default: return STR_W'($urandom_range(0, 127));
      endcase
   endfunction

   task automatic test_empty_window();
      offer_item(CMD_CLOSE, ID_W'($urandom), STR_W'($urandom), 1'($urandom));
      offer_item(CMD_LINE_END, ID_W'($urandom), STR_W'($urandom), 1'($urandom));
      offer_item(CMD_LINE_END, ID_W'($urandom), STR_W'($urandom), 1'($urandom));
      offer_item(CMD_CLOSE, ID_W'($urandom), STR_W'($urandom), 1'($urandom));
      drain_window();
   endtask

   task automatic test_report_rules();
      offer_item(CMD_REPORT, '0, 8'sd0, 1'b0);
      offer_item(CMD_REPORT, '1, 8'sd127, 1'b1);
      offer_item(CMD_REPORT, 31'd5, INVALID_STRENGTH, 1'b1);
      offer_item(CMD_REPORT, 31'd5, -8'sd1, 1'b1);
      offer_item(CMD_REPORT, 31'd5, 8'sh80, 1'b0);
      offer_item(CMD_REPORT, 31'd6, 8'sd98, 1'b0);
      offer_item(CMD_REPORT, 31'd6, 8'sd100, 1'b1);
      offer_item(CMD_UNKNOWN, 31'd6, 8'sd127, 1'b1);
      offer_item(CMD_LINE_END, '1, -8'sd1, 1'b1);
      offer_item(CMD_REPORT, '0, 8'sd1, 1'b0);
      offer_item(CMD_REPORT, '1, 8'sd0, 1'b0);
      offer_item(CMD_REPORT, 31'd7, 8'sd50, 1'b0);
      offer_item(CMD_LINE_END, '0, 8'sd0, 1'b0);
      offer_item(CMD_CLOSE, '0, 8'sd0, 1'b0);
      drain_window();
   endtask

   task automatic test_no_lines();
      offer_item(CMD_REPORT, 31'd9, 8'sd3, 1'b0);
      offer_item(CMD_REPORT, 31'd10, 8'sd127, 1'b1);
      offer_item(CMD_REPORT, 31'd9, 8'sd4, 1'b0);
      offer_item(CMD_CLOSE, '1, 8'sd0, 1'b0);
      drain_window();
   endtask

   task automatic test_full_table();
      for (int k = 0; k < TABLE_DEPTH; k++)
         offer_item(CMD_REPORT, ID_W'(32'h4000_0000 + k), STR_W'($urandom_range(0, 127)),
                    1'($urandom));
      for (int k = 0; k < 3; k++)
         offer_item(CMD_REPORT, ID_W'(32'h1000 + k), 8'sd20, 1'b1);
      offer_item(CMD_REPORT, ID_W'(32'h4000_0000), 8'sd127, 1'b1);
      offer_item(CMD_CLOSE, '0, 8'sd0, 1'b0);
      drain_window();
   endtask

   task automatic test_backpressure();
      for (int k = 0; k < 24; k++)
         offer_item(CMD_REPORT, ID_W'(200 + k), STR_W'($urandom_range(0, 127)), 1'($urandom));
      rsp_hold = HOLD_OFF;
      offer_item(CMD_CLOSE, '0, 8'sd0, 1'b0);
      for (int k = 0; k < 16; k++)
         offer_item(CMD_REPORT, ID_W'(300 + k), STR_W'($urandom_range(0, 127)), 1'($urandom));
      offer_item(CMD_CLOSE, '0, 8'sd0, 1'b0);
      drain_window();
   endtask

   task automatic run_random_window();
      logic [ID_W-1:0] pool [0:39];
      int n_ids;
      int n_lines;
      sender_quiet = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      n_ids = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
      n_lines = (n_ids > 8) ? $urandom_range(0, 2) : $urandom_range(0, 5);
      for (int k = 0; k < n_ids; k++)
         pool[k] = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
      for (int ln = 0; ln <= n_lines; ln++) begin
         for (int k = 0; k < n_ids; k++)
            if ($urandom_range(0, 2) != 0)
               offer_item(CMD_REPORT, pool[k], pick_strength(), 1'($urandom));
         // noise: unknown command or a stray id
         case ($urandom_range(0, 9))
            0: offer_item(CMD_UNKNOWN, ID_W'($urandom), STR_W'($urandom), 1'($urandom));
            1: offer_item(CMD_REPORT, ID_W'($urandom), pick_strength(), 1'($urandom));
            default: ;
         endcase
         if (ln < n_lines)
            offer_item(CMD_LINE_END, ID_W'($urandom), STR_W'($urandom), 1'($urandom));
      end
      offer_item(CMD_CLOSE, ID_W'($urandom), STR_W'($urandom), 1'($urandom));
   endtask

   task automatic test_random_windows();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) run_random_window();
      drain_window();
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.command = CMD_REPORT;
      req_if.transmitter_id = '0;
      req_if.strength = '0;
      req_if.serving = 1'b0;
      win_used = 0;
      win_lines = '0;
      win_drops = '0;
      mismatches = 0;
      items_sent = 0;
      results_checked = 0;
      windows_closed = 0;
      rsp_hold = 0;
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_window();
      test_report_rules();
      test_no_lines();
      test_full_table();
      test_backpressure();
      test_random_windows();

      $display("covered %0d request transactions, %0d results, %0d closed windows",
               items_sent, results_checked, windows_closed);
      $display("cases: empty and full table, ignored strengths, long output stall");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // result side ready, with random gaps and an occasional long hold-off
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (rsp_hold) @(negedge clock);
            rsp_hold = 0;
         end
         gap = receiver_quiet ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         @(negedge clock);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_checked++;
         if (expected_window_results.size() == 0) begin
            $error("result transaction with nothing expected, entry_id %0h", rsp_if.entry_id);
            mismatches++;
         end else begin
            want = expected_window_results.pop_front();
            check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_if.entry_valid));
            check_field("entry_id", 32'(want.entry_id), 32'(rsp_if.entry_id));
            check_field("average_strength", 32'(want.average_strength),
                        32'(rsp_if.average_strength));
            check_field("was_serving", 32'(want.was_serving), 32'(rsp_if.was_serving));
            check_field("dropped_reports", 32'(want.dropped_reports),
                        32'(rsp_if.dropped_reports));
            check_field("last", 32'(want.last), 32'(rsp_if.last));
         end
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      wait (!reset);
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("no transaction for %0d cycles, %0d results outstanding", STALL_LIMIT,
               expected_window_results.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
rtl/swa_pkg.sv
rtl/swa_if.sv
rtl/swa_ram.sv
rtl/swa_div.sv
rtl/signal_window_aggregator_top.sv
bench/testbench.sv
